// ----- rtl/anhm_pkg.sv -----
// Shared types and constants of the advertisement name heartbeat monitor.
`timescale 1ns / 1ps

package anhm_pkg;

    localparam int NAME_BYTES    = 8;
    localparam int MAX_NAME_DATA = 62;
    localparam int TIME_BITS     = 32;
    localparam int GAP_BITS      = 32;
    localparam int NAME_LEN_BITS = 4;
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 2;
    localparam int OUT_BITS      = 40;

    localparam logic [7:0] NAME_TYPE = 8'h08;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_TEXT    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NAME_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PERIOD   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_INACTIVE = 2'd3;

    localparam logic [63:0]              RST_NAME_TEXT    = 64'd110442423936327;
    localparam logic [NAME_LEN_BITS-1:0] RST_NAME_LENGTH  = 4'd6;
    localparam logic [31:0]              RST_MAX_PERIOD   = 32'd900;
    localparam logic [31:0]              RST_MAX_INACTIVE = 32'd300000;

    typedef struct packed {
        logic       mode;       // 1 = millisecond tick
        logic [7:0] data_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic tick;
        logic matched;
    } parse_evt_t;

    // fills the result up to OUT_BITS
    typedef struct packed {
        logic [OUT_BITS-GAP_BITS-4:0] pad;
        logic [GAP_BITS-1:0]          gap_ms;
        logic                         match_in_time;
        logic                         name_matched;
        logic                         link_ok;
    } result_t;

endpackage

// ----- rtl/adv_name_heartbeat_monitor.sv -----
// Top level of the advertisement name heartbeat monitor.
`timescale 1ns / 1ps

// Each input transfer is either an advertisement payload byte (s_tuser = 0,
// byte in s_tdata[7:0], s_tlast on the final byte) or a one-millisecond tick
// (s_tuser = 1). Every input transfer yields exactly one output transfer two
// stages later: an input register, then the structure parser and the
// match/validity timers updating into the output register. Throughput is one
// item per cycle while m_tready is high; the output register lets the next
// item be taken while a result is still waiting. link_ok reports whether the
// time since the last in-period name match is within max_inactive_ms.
// Configuration writes take effect at once and must be made while idle.
module adv_name_heartbeat_monitor (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_we,
    input  logic [anhm_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [anhm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,  // [7:0] data_byte
    input  logic                                s_tuser,  // [0] mode (1 = tick)
    input  logic                                s_tlast,  // last_byte
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] link_ok, [1] name_matched, [2] match_in_time, [34:3] gap_ms, rest 0
    output logic [anhm_pkg::OUT_BITS-1:0]       m_tdata
);
    import anhm_pkg::*;

    // configuration registers
    logic [63:0]              name_text_reg;
    logic [NAME_LEN_BITS-1:0] name_length_reg;
    logic [31:0]              max_period_reg;
    logic [31:0]              max_inactive_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_text_reg    <= RST_NAME_TEXT;
            name_length_reg  <= RST_NAME_LENGTH;
            max_period_reg   <= RST_MAX_PERIOD;
            max_inactive_reg <= RST_MAX_INACTIVE;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_NAME_TEXT:    name_text_reg    <= cfg_wdata[63:0];
                CFG_NAME_LENGTH:  name_length_reg  <= cfg_wdata[NAME_LEN_BITS-1:0];
                CFG_MAX_PERIOD:   max_period_reg   <= cfg_wdata[31:0];
                CFG_MAX_INACTIVE: max_inactive_reg <= cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // input stage
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    logic    advance;
    logic    s_fire;

    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_item_reg.mode      <= s_tuser;
            in_item_reg.data_byte <= s_tdata;
            in_item_reg.last_byte <= s_tlast;
        end
    end

    // processing stage
    parse_evt_t evt;
    result_t    res;

    anhm_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (advance),
        .item        (in_item_reg),
        .name_text   (name_text_reg),
        .name_length (name_length_reg),
        .evt         (evt)
    );

    anhm_timer u_timer (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (advance),
        .evt             (evt),
        .max_period_ms   (max_period_reg),
        .max_inactive_ms (max_inactive_reg),
        .res             (res)
    );

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // checks
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while both stages are full");

    a_in_time_needs_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!out_data_reg.match_in_time || out_data_reg.name_matched))
        else $error("match_in_time without a match");

    a_gap_zero_no_match: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !out_data_reg.name_matched) |-> (out_data_reg.gap_ms == '0))
        else $error("gap reported without a match");

    a_valid_match_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_data_reg.match_in_time) |-> out_data_reg.link_ok)
        else $error("link not ok right after a valid match");

    a_no_unused_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> (out_data_reg.pad == '0))
        else $error("pad bits set in result");

endmodule

// ----- rtl/anhm_parser.sv -----
// Length/type/data walker that flags completed name structures.
`timescale 1ns / 1ps

module anhm_parser (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  anhm_pkg::item_t                  item,
    input  logic [63:0]                      name_text,
    input  logic [anhm_pkg::NAME_LEN_BITS-1:0] name_length,
    output anhm_pkg::parse_evt_t             evt
);
    import anhm_pkg::*;

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_DATA = 2'd2;
    localparam logic [1:0] PH_STOP = 2'd3;

    logic [1:0] phase_reg, phase_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic       is_name_reg, is_name_next;
    logic       equal_reg, equal_next;
    logic [7:0] pos_reg, pos_next;

    logic [NAME_LEN_BITS-1:0] eff_len;
    logic [7:0]               name_ch;
    logic                     done;

    assign eff_len = (name_length > NAME_LEN_BITS'(NAME_BYTES)) ?
                     NAME_LEN_BITS'(NAME_BYTES) : name_length;
    assign name_ch = name_text[{pos_reg[2:0], 3'b000} +: 8];

    always_comb begin
        phase_next      = phase_reg;
        bytes_left_next = bytes_left_reg;
        is_name_next    = is_name_reg;
        equal_next      = equal_reg;
        pos_next        = pos_reg;
        done            = 1'b0;
        case (phase_reg)
            PH_LEN: begin
                if (item.data_byte == 8'd0) begin
                    phase_next = PH_STOP;
                end else begin
                    bytes_left_next = item.data_byte - 8'd1;
                    phase_next      = PH_TYPE;
                end
            end
            PH_TYPE: begin
                is_name_next = (item.data_byte == NAME_TYPE) &&
                               (bytes_left_reg <= 8'(MAX_NAME_DATA));
                equal_next   = 1'b1;
                pos_next     = 8'd0;
                if (bytes_left_reg == 8'd0) begin
                    done = 1'b1;
                end else begin
                    phase_next = PH_DATA;
                end
            end
            PH_DATA: begin
                if (pos_reg < 8'(eff_len)) begin
                    if (item.data_byte != name_ch) begin
                        equal_next = 1'b0;
                    end
                end else if (pos_reg == 8'(eff_len)) begin
                    // terminator must be NUL if the data goes on
                    if (item.data_byte != 8'd0) begin
                        equal_next = 1'b0;
                    end
                end
                if (pos_reg != 8'hFF) begin
                    pos_next = pos_reg + 8'd1;
                end
                bytes_left_next = bytes_left_reg - 8'd1;
                if (bytes_left_next == 8'd0) begin
                    done = 1'b1;
                end
            end
            default: ;  // stopped: wait for last byte
        endcase
        if (done) begin
            phase_next = PH_LEN;
        end
        if (item.last_byte) begin
            phase_next      = PH_LEN;
            bytes_left_next = 8'd0;
        end
    end

    assign evt.tick    = item.mode;
    assign evt.matched = !item.mode && done && is_name_next && equal_next &&
                         (pos_next >= 8'(eff_len));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LEN;
            bytes_left_reg <= 8'd0;
            is_name_reg    <= 1'b0;
            equal_reg      <= 1'b0;
            pos_reg        <= 8'd0;
        end else if (en && !item.mode) begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            is_name_reg    <= is_name_next;
            equal_reg      <= equal_next;
            pos_reg        <= pos_next;
        end
    end

endmodule

// ----- rtl/anhm_timer.sv -----
// Millisecond counters since last match and last valid match.
`timescale 1ns / 1ps

module anhm_timer (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  anhm_pkg::parse_evt_t evt,
    input  logic [31:0]          max_period_ms,
    input  logic [31:0]          max_inactive_ms,
    output anhm_pkg::result_t    res
);
    import anhm_pkg::*;

    localparam int WIDE = TIME_BITS + GAP_BITS;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [GAP_BITS-1:0]  GAP_MAX  = '1;

    logic [TIME_BITS-1:0] since_match_reg, since_match_next;
    logic [TIME_BITS-1:0] since_valid_reg, since_valid_next;
    logic                 in_time;

    assign in_time = WIDE'(since_match_reg) <= WIDE'(max_period_ms);

    always_comb begin
        since_match_next = since_match_reg;
        since_valid_next = since_valid_reg;
        if (evt.tick) begin
            if (since_match_reg != TIME_MAX) since_match_next = since_match_reg + 1'b1;
            if (since_valid_reg != TIME_MAX) since_valid_next = since_valid_reg + 1'b1;
        end else if (evt.matched) begin
            since_match_next = '0;
            if (in_time) since_valid_next = '0;
        end
    end

    always_comb begin
        res = '0;
        res.link_ok = WIDE'(since_valid_next) <= WIDE'(max_inactive_ms);
        if (evt.matched) begin
            res.name_matched  = 1'b1;
            res.match_in_time = in_time;
            res.gap_ms = (WIDE'(since_match_reg) > WIDE'(GAP_MAX)) ?
                         GAP_MAX : GAP_BITS'(since_match_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            since_match_reg <= '0;
            since_valid_reg <= '0;
        end else if (en) begin
            since_match_reg <= since_match_next;
            since_valid_reg <= since_valid_next;
        end
    end

endmodule
